// ----- src/idfl_pkg.sv -----
// Package for the identifier free-list allocator.
// Command modes, result status codes and fixed field widths; no dependencies.
package idfl_pkg;

  localparam int MODE_W   = 3;
  localparam int FIELD_W  = 16;
  localparam int IDOUT_W  = 8;
  localparam int STATUS_W = 3;

  localparam logic [FIELD_W-1:0] NO_NODE = 16'hFFFF;

  typedef enum logic [MODE_W-1:0] {
    MODE_RESET_IDS  = 3'd0,
    MODE_ALLOC      = 3'd1,
    MODE_FREE       = 3'd2,
    MODE_REMOVE     = 3'd3,
    MODE_SET_OFFSET = 3'd4,
    MODE_CLEAR      = 3'd5
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_INVALID   = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

endpackage

// ----- src/idfl_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module idfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/identifier_free_list_top.sv -----
// Identifier free-list allocator: top level.
// Depends on idfl_pkg (modes, status codes) and idfl_ram (stack and offset memories).
//
// Hands out identifiers 0..MAX_IDS-1 from a stack of free identifiers kept in
// one RAM, and keeps a node offset per identifier in a second RAM. A command is
// taken when start is high and busy is low; its single result beat appears
// registered on identifier_out/status once the command finishes, with done high
// for exactly that cycle. The receiver cannot stall: sample it when done is
// high. How each command is carried out:
//   free, set offset, unused modes, allocate on empty stack: answered directly
//   allocate: one stack RAM read of the top entry
//   remove, clear: one pass over the stack through the RAM read port, the
//     last read landing before the beat is posted; remove shifts entries down
//     in the same pass
//   reset ids: one stack entry rewritten per cycle
// After rst, busy stays high while the stack is filled with 0..MAX_IDS-1 and
// every offset is set to all ones (no node); no command is taken during that
// pass.
module identifier_free_list_top
  import idfl_pkg::*;
#(
  parameter int MAX_IDS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [MODE_W-1:0]   mode,
  input  logic [FIELD_W-1:0]  identifier,
  input  logic [FIELD_W-1:0]  offset,
  output logic                done,
  output logic [IDOUT_W-1:0]  identifier_out,
  output logic [STATUS_W-1:0] status
);

  localparam int ID_W  = $clog2(MAX_IDS);
  localparam int CNT_W = $clog2(MAX_IDS + 1);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ALLOC,
    S_REFILL,
    S_REMOVE,
    S_CLEAR
  } state_t;

  state_t            state;
  logic [ID_W-1:0]   sweep;     // refill / init position
  logic [CNT_W-1:0]  count;     // free identifiers on the stack
  logic [CNT_W-1:0]  rd_idx;    // next stack index to read in a scan
  logic              pend_vld;  // a scan read is landing this cycle
  logic [ID_W-1:0]   pend_idx;  // index of the landing read
  logic              found;
  logic [FIELD_W-1:0] cmd_id;

  // RAM ports
  logic              stk_we;
  logic [ID_W-1:0]   stk_waddr;
  logic [ID_W-1:0]   stk_wdata;
  logic [ID_W-1:0]   stk_raddr;
  logic [ID_W-1:0]   stk_rdata;
  logic              off_we;
  logic [ID_W-1:0]   off_waddr;
  logic [FIELD_W-1:0] off_wdata;

  mode_t              mode_in;
  logic               accept;
  logic               id_ok;
  logic [ID_W-1:0]    id_idx;
  logic [CNT_W-1:0]   cnt_m1;
  logic               stack_full;
  logic               scan_more;
  logic [ID_W+7:0]    rd_ext;
  logic [FIELD_W-1:0] rd_wide;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign mode_in    = mode_t'(mode);
  assign id_ok      = (identifier < FIELD_W'(MAX_IDS));
  assign id_idx     = identifier[ID_W-1:0];
  assign cnt_m1     = count - CNT_W'(1);
  assign stack_full = (count >= CNT_W'(MAX_IDS));
  assign scan_more  = (rd_idx < count);
  assign rd_ext     = {8'b0, stk_rdata};
  assign rd_wide    = {{(FIELD_W-ID_W){1'b0}}, stk_rdata};

  // Memory access steering
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = '0;
    stk_wdata = '0;
    stk_raddr = '0;
    off_we    = 1'b0;
    off_waddr = '0;
    off_wdata = NO_NODE;
    unique case (state)
      S_INIT: begin
        stk_we    = 1'b1;
        stk_waddr = sweep;
        stk_wdata = sweep;
        off_we    = 1'b1;
        off_waddr = sweep;
      end
      S_REFILL: begin
        stk_we    = 1'b1;
        stk_waddr = sweep;
        stk_wdata = sweep;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (mode_in)
            MODE_ALLOC: begin
              stk_raddr = cnt_m1[ID_W-1:0];
            end
            MODE_FREE: begin
              if (id_ok) begin
                off_we    = 1'b1;
                off_waddr = id_idx;
                if (!stack_full) begin
                  stk_we    = 1'b1;
                  stk_waddr = count[ID_W-1:0];
                  stk_wdata = id_idx;
                end
              end
            end
            MODE_SET_OFFSET: begin
              if (id_ok) begin
                off_we    = 1'b1;
                off_waddr = id_idx;
                off_wdata = offset;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_REMOVE: begin
        stk_raddr = rd_idx[ID_W-1:0];
        // once the match is passed, each landing entry moves down one slot
        if (pend_vld && found) begin
          stk_we    = 1'b1;
          stk_waddr = pend_idx - ID_W'(1);
          stk_wdata = stk_rdata;
        end
      end
      S_CLEAR: begin
        stk_raddr = rd_idx[ID_W-1:0];
        if (pend_vld) begin
          off_we    = 1'b1;
          off_waddr = stk_rdata;
        end
      end
      S_ALLOC: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer, stack pointer and result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      sweep    <= '0;
      count    <= CNT_W'(MAX_IDS);
      rd_idx   <= '0;
      pend_vld <= 1'b0;
      found    <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_INIT, S_REFILL: begin
          sweep <= sweep + ID_W'(1);
          if (sweep == ID_W'(MAX_IDS - 1)) begin
            sweep <= '0;
            count <= CNT_W'(MAX_IDS);
            state <= S_IDLE;
            if (state == S_REFILL) begin
              done           <= 1'b1;
              identifier_out <= '0;
              status         <= ST_OK;
            end
          end
        end
        S_IDLE: begin
          if (start) begin
            identifier_out <= '0;
            unique case (mode_in)
              MODE_RESET_IDS: begin
                sweep <= '0;
                state <= S_REFILL;
              end
              MODE_ALLOC: begin
                if (count == '0) begin
                  done   <= 1'b1;
                  status <= ST_EMPTY;
                end else begin
                  count <= cnt_m1;
                  state <= S_ALLOC;
                end
              end
              MODE_FREE: begin
                done <= 1'b1;
                if (!id_ok) begin
                  status <= ST_INVALID;
                end else if (stack_full) begin
                  status <= ST_FULL;
                end else begin
                  count  <= count + CNT_W'(1);
                  status <= ST_OK;
                end
              end
              MODE_REMOVE: begin
                rd_idx   <= '0;
                pend_vld <= 1'b0;
                found    <= 1'b0;
                cmd_id   <= identifier;
                state    <= S_REMOVE;
              end
              MODE_SET_OFFSET: begin
                done   <= 1'b1;
                status <= id_ok ? ST_OK : ST_INVALID;
              end
              MODE_CLEAR: begin
                rd_idx   <= '0;
                pend_vld <= 1'b0;
                state    <= S_CLEAR;
              end
              default: begin
                done   <= 1'b1;
                status <= ST_INVALID;
              end
            endcase
          end
        end
        S_ALLOC: begin
          done           <= 1'b1;
          identifier_out <= rd_ext[7:0];
          status         <= ST_OK;
          state          <= S_IDLE;
        end
        S_REMOVE, S_CLEAR: begin
          if (scan_more) begin
            pend_vld <= 1'b1;
            pend_idx <= rd_idx[ID_W-1:0];
            rd_idx   <= rd_idx + CNT_W'(1);
          end else begin
            pend_vld <= 1'b0;
          end
          // lowest match only
          if (state == S_REMOVE && pend_vld && !found && rd_wide == cmd_id) begin
            found <= 1'b1;
          end
          if (!scan_more && !pend_vld) begin
            done           <= 1'b1;
            identifier_out <= '0;
            state          <= S_IDLE;
            if (state == S_REMOVE) begin
              if (found) begin
                count  <= cnt_m1;
                status <= ST_OK;
              end else begin
                status <= ST_NOT_FOUND;
              end
            end else begin
              status <= ST_OK;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  idfl_ram #(
    .WIDTH (ID_W),
    .DEPTH (MAX_IDS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // offsets are written only; nothing reads them back here
  idfl_ram #(
    .WIDTH (FIELD_W),
    .DEPTH (MAX_IDS)
  ) u_offset_ram (
    .clk   (clk),
    .we    (off_we),
    .waddr (off_waddr),
    .wdata (off_wdata),
    .raddr (off_waddr),
    .rdata ()
  );

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_IDS))
    else $error("free count above MAX_IDS");

  a_idout_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> identifier_out == '0)
    else $error("identifier handed out on a failed beat");

  a_alloc_pop: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MODE_ALLOC && count != '0) |=> count == $past(cnt_m1))
    else $error("allocate did not pop the stack");

  a_shift_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_REMOVE && pend_vld && found) |-> pend_idx != '0)
    else $error("remove shift below stack bottom");

  a_scan_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR || (state == S_REMOVE && !(done))) |->
      (rd_idx <= count))
    else $error("scan index ran past the stack");
`endif

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the identifier free-list allocator.
// Depends on idfl_pkg and identifier_free_list_top; runs a directed table and
// then random command beats.
module tb_top
  import idfl_pkg::*;
();

  localparam int N_IDS      = 256;
  localparam int CLK_PERIOD = 20;
  localparam int N_RANDOM   = 1800;
  // Longest command is a walk over a full stack (remove or clear).
  localparam int END_WAIT   = N_IDS + 8;
  localparam int DRAIN_CAP  = 100000;
  localparam int N_DIRECTED = 24;

  // Mode codes with no command behind them; the block must answer invalid.
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                start      = 1'b0;
  logic [MODE_W-1:0]   mode       = MODE_RESET_IDS;
  logic [FIELD_W-1:0]  identifier = '0;
  logic [FIELD_W-1:0]  offset     = '0;
  logic                busy;
  logic                done;
  logic [IDOUT_W-1:0]  identifier_out;
  logic [STATUS_W-1:0] status;

  identifier_free_list_top #(
    .MAX_IDS(N_IDS)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .identifier    (identifier),
    .offset        (offset),
    .done          (done),
    .identifier_out(identifier_out),
    .status        (status)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // One row of the directed table. When pinned is set, the expected result is
  // the one typed into the row; otherwise the predictor supplies it.
  typedef struct packed {
    logic [MODE_W-1:0]  md;
    logic [FIELD_W-1:0] id;
    logic [FIELD_W-1:0] off;
    logic               pinned;
    logic [IDOUT_W-1:0] id_out;
    status_t            st;
  } cmd_row_t;

  // One expected result beat, tagged with the mode that caused it.
  typedef struct packed {
    logic [MODE_W-1:0]  md;
    logic [IDOUT_W-1:0] id_out;
    status_t            st;
  } alloc_result_t;

  // Starts from the state right after the clearing pass: stack 0..255, all
  // offsets "no node". Walks the edge cases: top-of-stack pops, out-of-range
  // frees and offset writes, a duplicate free, the push onto a full stack,
  // removal of the lowest match then its duplicate, the spare modes, clear,
  // and a refill followed by a pop that must again hand out the top entry.
  localparam cmd_row_t DIRECTED [N_DIRECTED] = '{
    '{MODE_ALLOC,      16'd0,     16'd0,     1'b1, 8'd255, ST_OK},
    '{MODE_ALLOC,      16'd0,     16'd0,     1'b1, 8'd254, ST_OK},
    '{MODE_ALLOC,      16'd0,     16'd0,     1'b0, 8'd0,   ST_OK},
    '{MODE_FREE,       16'hFFFF,  16'd0,     1'b1, 8'd0,   ST_INVALID},
    '{MODE_FREE,       16'd256,   16'd0,     1'b1, 8'd0,   ST_INVALID},
    '{MODE_SET_OFFSET, 16'hFFFF,  16'd0,     1'b1, 8'd0,   ST_INVALID},
    '{MODE_SET_OFFSET, 16'd0,     16'd0,     1'b1, 8'd0,   ST_OK},
    '{MODE_SET_OFFSET, 16'd255,   16'hFFFF,  1'b1, 8'd0,   ST_OK},
    '{MODE_FREE,       16'd255,   16'd0,     1'b0, 8'd0,   ST_OK},
    '{MODE_FREE,       16'd0,     16'd0,     1'b0, 8'd0,   ST_OK},
    '{MODE_FREE,       16'd254,   16'd0,     1'b0, 8'd0,   ST_OK},
    '{MODE_FREE,       16'd1,     16'd0,     1'b1, 8'd0,   ST_FULL},
    '{MODE_REMOVE,     16'hFFFF,  16'd0,     1'b1, 8'd0,   ST_NOT_FOUND},
    '{MODE_REMOVE,     16'd0,     16'd0,     1'b0, 8'd0,   ST_OK},
    '{MODE_REMOVE,     16'd0,     16'd0,     1'b0, 8'd0,   ST_OK},
    '{MODE_REMOVE,     16'd0,     16'd0,     1'b0, 8'd0,   ST_OK},
    '{MODE_REMOVE,     16'h00FF,  16'd0,     1'b0, 8'd0,   ST_OK},
    '{MODE_SPARE_6,    16'hAAAA,  16'h5555,  1'b1, 8'd0,   ST_INVALID},
    '{MODE_SPARE_7,    16'h5555,  16'hAAAA,  1'b1, 8'd0,   ST_INVALID},
    '{MODE_CLEAR,      16'd0,     16'd0,     1'b1, 8'd0,   ST_OK},
    '{MODE_RESET_IDS,  16'd0,     16'd0,     1'b1, 8'd0,   ST_OK},
    '{MODE_ALLOC,      16'd0,     16'd0,     1'b1, 8'd255, ST_OK},
    '{MODE_SET_OFFSET, 16'h00AA,  16'h5555,  1'b0, 8'd0,   ST_OK},
    '{MODE_CLEAR,      16'd0,     16'd0,     1'b0, 8'd0,   ST_OK}
  };

  // Allocator state as predicted: free stack, its fill level, offset table.
  logic [IDOUT_W-1:0] free_ids    [N_IDS];
  int                 free_cnt;
  logic [FIELD_W-1:0] node_offset [N_IDS];

  alloc_result_t pending_results[$];
  status_t       last_status;
  bit            idle_off = 1'b0;

  int errors    = 0;
  int n_sent    = 0;
  int n_checked = 0;
  int n_empty   = 0;
  int n_full    = 0;
  int n_invalid = 0;
  int n_missed  = 0;
  int n_by_mode [8];

  function automatic void refill_free_ids();
    for (int k = 0; k < N_IDS; k++) free_ids[k] = IDOUT_W'(k);
    free_cnt = N_IDS;
  endfunction

  // Applies one command to the predicted state and returns its result beat.
  function automatic void predict_alloc(input logic [MODE_W-1:0] md,
                                        input logic [FIELD_W-1:0] id,
                                        input logic [FIELD_W-1:0] off,
                                        output logic [IDOUT_W-1:0] id_out,
                                        output status_t st);
    int hit;
    id_out = '0;
    st     = ST_OK;
    hit    = -1;
    case (md)
      MODE_RESET_IDS: begin
        // offsets survive a refill
        refill_free_ids();
      end
      MODE_ALLOC: begin
        if (free_cnt == 0) begin
          st = ST_EMPTY;
        end else begin
          free_cnt--;
          id_out = free_ids[free_cnt];
        end
      end
      MODE_FREE: begin
        if (id >= N_IDS) begin
          st = ST_INVALID;
        end else begin
          // offset goes to "no node" even when the push is dropped
          node_offset[int'(id)] = NO_NODE;
          if (free_cnt >= N_IDS) begin
            st = ST_FULL;
          end else begin
            free_ids[free_cnt] = IDOUT_W'(id);
            free_cnt++;
          end
        end
      end
      MODE_REMOVE: begin
        st = ST_NOT_FOUND;
        for (int k = 0; k < free_cnt; k++) begin
          if (hit < 0 && id == FIELD_W'(free_ids[k])) hit = k;
        end
        if (hit >= 0) begin
          // close the gap: entries above the match move down one place
          for (int k = hit; k < free_cnt - 1; k++) free_ids[k] = free_ids[k + 1];
          free_cnt--;
          st = ST_OK;
        end
      end
      MODE_SET_OFFSET: begin
        if (id >= N_IDS) st = ST_INVALID;
        else node_offset[int'(id)] = off;
      end
      MODE_CLEAR: begin
        for (int k = 0; k < free_cnt; k++) node_offset[free_ids[k]] = NO_NODE;
      end
      default: begin
        st = ST_INVALID;
      end
    endcase
  endfunction

  // Sends one command beat after a random idle gap, waits for it to be taken,
  // then queues the result it must produce.
  task automatic issue_cmd(input logic [MODE_W-1:0] md, input logic [FIELD_W-1:0] id,
                           input logic [FIELD_W-1:0] off, input logic pinned,
                           input logic [IDOUT_W-1:0] pin_id, input status_t pin_st);
    int                 gap;
    logic [IDOUT_W-1:0] p_id;
    status_t            p_st;
    alloc_result_t      res;
    // runs of back-to-back beats now and then
    if ($urandom_range(0, 39) == 0) idle_off = !idle_off;
    gap = idle_off ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    mode       <= md;
    identifier <= id;
    offset     <= off;
    // accepted at the first edge that sees start high and busy low
    do @(posedge clk); while (busy);
    predict_alloc(md, id, off, p_id, p_st);
    res.md     = md;
    res.id_out = pinned ? pin_id : p_id;
    res.st     = pinned ? pin_st : p_st;
    pending_results.push_back(res);
    last_status = p_st;
    n_sent++;
    n_by_mode[md]++;
    if (p_st == ST_EMPTY) n_empty++;
    if (p_st == ST_FULL) n_full++;
    if (p_st == ST_INVALID) n_invalid++;
  endtask

  // Result beats last one cycle and cannot be held off: compare on every
  // edge where done is high, against the oldest expectation.
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual id %0d status %0d",
                 $time, identifier_out, status);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (identifier_out !== want.id_out) begin
          errors++;
          $display("%0t: mode %0d identifier_out: expected %0d, actual %0d",
                   $time, want.md, want.id_out, identifier_out);
        end
        if (status !== want.st) begin
          errors++;
          $display("%0t: mode %0d status: expected %0d, actual %0d",
                   $time, want.md, want.st, status);
        end
      end
    end
  end

  initial begin
    int                 r;
    int                 wait_cnt;
    bit                 draining;
    logic [MODE_W-1:0]  md;
    logic [FIELD_W-1:0] id;
    logic [FIELD_W-1:0] off;

    foreach (n_by_mode[i]) n_by_mode[i] = 0;
    refill_free_ids();
    foreach (node_offset[i]) node_offset[i] = NO_NODE;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      issue_cmd(DIRECTED[i].md, DIRECTED[i].id, DIRECTED[i].off,
                DIRECTED[i].pinned, DIRECTED[i].id_out, DIRECTED[i].st);
    end

    // Random part. The mix leans toward allocate while draining and toward
    // free while filling, so the stack swings between empty and full and
    // both boundary statuses come up repeatedly. Refills only while filling,
    // otherwise they would keep the stack from ever running dry.
    draining = 1'b1;
    repeat (N_RANDOM) begin
      r = $urandom_range(0, 99);
      if (r < (draining ? 60 : 20)) md = MODE_ALLOC;
      else if (r < (draining ? 72 : 70)) md = MODE_FREE;
      else if (r < 82) md = MODE_REMOVE;
      else if (r < 91) md = MODE_SET_OFFSET;
      else if (r < 95) md = MODE_CLEAR;
      else if (r < 97) md = draining ? MODE_ALLOC : MODE_RESET_IDS;
      else md = r[0] ? MODE_SPARE_7 : MODE_SPARE_6;

      // mostly in range, some beyond MAX_IDS, some fully random
      case ($urandom_range(0, 9))
        0:       id = FIELD_W'($urandom_range(N_IDS, 65535));
        1:       id = FIELD_W'($urandom);
        default: id = FIELD_W'($urandom_range(0, N_IDS - 1));
      endcase
      // remove: half the time pick something known to be on the stack
      if (md == MODE_REMOVE && free_cnt > 0 && $urandom_range(0, 1) == 1)
        id = FIELD_W'(free_ids[$urandom_range(0, free_cnt - 1)]);
      off = ($urandom_range(0, 15) == 0) ? NO_NODE : FIELD_W'($urandom);

      issue_cmd(md, id, off, 1'b0, '0, ST_OK);

      if (draining && last_status == ST_EMPTY && $urandom_range(0, 2) == 0) draining = 1'b0;
      if (!draining && last_status == ST_FULL && $urandom_range(0, 2) == 0) draining = 1'b1;
    end
    start <= 1'b0;

    wait_cnt = 0;
    while (pending_results.size() != 0 && wait_cnt < DRAIN_CAP) begin
      @(posedge clk);
      wait_cnt++;
    end
    if (pending_results.size() != 0) begin
      n_missed = pending_results.size();
      errors += n_missed;
      $display("%0t: %0d expected results never arrived", $time, n_missed);
    end
    // catch any stray beat after the last expected one
    repeat (END_WAIT) @(posedge clk);

    $display("Sent %0d commands, checked %0d results (empty %0d, full %0d, invalid %0d).",
             n_sent, n_checked, n_empty, n_full, n_invalid);
    $display("Per mode: refill %0d alloc %0d free %0d remove %0d offset %0d clear %0d%s%0d",
             n_by_mode[0], n_by_mode[1], n_by_mode[2], n_by_mode[3], n_by_mode[4],
             n_by_mode[5], " spare ", n_by_mode[6] + n_by_mode[7]);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (every beat a full gap plus a
  // full stack walk, the clearing pass after reset and the final drain).
  initial begin
    #(CLK_PERIOD * 3000000);
    $display("Mismatches found");
    $finish;
  end

endmodule
